// File: rtl/core/qdec_pkg.sv
// Shared types and constants for the dual quadrature decoder.
`timescale 1ns / 1ps

package qdec_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFilterEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFilterTime = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvertLeft = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInvertRight = 2'd3;

  // Input action codes.
  localparam logic ActEdge = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic              action;
    logic              encoder_sel;
    logic              which_line;
    logic              level_a;
    logic              level_b;
    logic [StampW-1:0] stamp;
  } in_word_t;

  typedef struct packed {
    logic              event_valid;
    logic [2:0]        event_code;
    logic [StampW-1:0] event_time;
    logic [CountW-1:0] count_left;
    logic [CountW-1:0] count_right;
  } out_word_t;

endpackage

// File: rtl/core/qdec_word_if.sv
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps

interface qdec_word_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// File: rtl/core/dual_quadrature_decoder_filtered.sv
// Dual x4 quadrature decoder with per-line edge filter: one word in, one word out, each
// cycle while the output side does not stall. A word is registered in the input register on
// entry, decoded against the position counters and the last-edge timestamps and then loaded
// into the output register, from which its result is presented. The filter uses a single
// 32-bit subtract and compare. The input register keeps taking words while the output
// register is occupied, as long as the output side drains it. Configuration is to be
// written by the user only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module dual_quadrature_decoder_filtered (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qdec_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qdec_pkg::CfgDataW-1:0]  cfg_wdata_i,
  qdec_word_if.sink                      in_i,
  qdec_word_if.source                    out_o
);

  // Configuration registers.
  logic                          filt_en_q;
  logic [qdec_pkg::StampW-1:0]   filt_time_q;
  logic                          inv_left_q;
  logic                          inv_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q   <= 1'b0;
      filt_time_q <= '0;
      inv_left_q  <= 1'b0;
      inv_right_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qdec_pkg::CfgFilterEnable: filt_en_q   <= cfg_wdata_i[0];
        qdec_pkg::CfgFilterTime:   filt_time_q <= cfg_wdata_i[qdec_pkg::StampW-1:0];
        qdec_pkg::CfgInvertLeft:   inv_left_q  <= cfg_wdata_i[0];
        qdec_pkg::CfgInvertRight:  inv_right_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic                in_valid_q;
  qdec_pkg::in_word_t  in_word_q;
  logic                out_valid_q;
  qdec_pkg::out_word_t out_word_q;
  logic                advance;
  logic                in_take;
  logic                move;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = advance || !in_valid_q;
  assign in_take     = in_i.valid && in_i.ready;
  assign move        = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_i.word;
    end
  end

  // Decoder state.
  logic [qdec_pkg::CountW-1:0] pos_q [2];
  logic [qdec_pkg::StampW-1:0] last_q [4];

  logic [1:0]                  slot;
  logic [qdec_pkg::StampW-1:0] delta;
  logic                        blocked;
  logic                        edge_ok;
  logic                        up;
  logic                        lvl;
  logic [qdec_pkg::CountW-1:0] cnt_sel;
  logic [qdec_pkg::CountW-1:0] cnt_step;
  logic [qdec_pkg::CountW-1:0] pos_d [2];
  qdec_pkg::out_word_t         out_word_d;

  always_comb begin
    slot     = {in_word_q.encoder_sel, in_word_q.which_line};
    delta    = in_word_q.stamp - last_q[slot];
    // With the filter enabled, an edge closer than the filter time to the last accepted one on its line is dropped.
    blocked  = filt_en_q && (delta < filt_time_q);
    edge_ok  = (in_word_q.action == qdec_pkg::ActEdge) && !blocked;
    lvl      = in_word_q.which_line ? in_word_q.level_b : in_word_q.level_a;
    up       = in_word_q.which_line ? (in_word_q.level_a != in_word_q.level_b)
                                    : (in_word_q.level_a == in_word_q.level_b);
    cnt_sel  = pos_q[in_word_q.encoder_sel];
    cnt_step = up ? cnt_sel + qdec_pkg::CountW'(1) : cnt_sel - qdec_pkg::CountW'(1);

    pos_d[0] = pos_q[0];
    pos_d[1] = pos_q[1];
    if (in_word_q.action == qdec_pkg::ActClear) begin
      pos_d[0] = '0;
      pos_d[1] = '0;
    end else if (edge_ok) begin
      pos_d[in_word_q.encoder_sel] = cnt_step;
    end

    out_word_d.event_valid = edge_ok;
    out_word_d.event_code  = edge_ok ? {in_word_q.encoder_sel, in_word_q.which_line, !lvl}
                                     : 3'd0;
    out_word_d.event_time  = edge_ok ? in_word_q.stamp : '0;
    out_word_d.count_left  = inv_left_q ? (qdec_pkg::CountW'(0) - pos_d[0]) : pos_d[0];
    out_word_d.count_right = inv_right_q ? (qdec_pkg::CountW'(0) - pos_d[1]) : pos_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      last_q[0] <= '0;
      last_q[1] <= '0;
      last_q[2] <= '0;
      last_q[3] <= '0;
    end else if (move) begin
      pos_q[0] <= pos_d[0];
      pos_q[1] <= pos_d[1];
      if (edge_ok) begin
        last_q[slot] <= in_word_q.stamp;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // A result without an event carries no code and no time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_word_q.event_valid) |->
      (out_word_q.event_code == 3'd0 && out_word_q.event_time == '0))
    else $error("event fields set on a result without an event");

  // A clear command reports both counts as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_word_q.action == qdec_pkg::ActClear) |=>
      (out_word_q.count_left == '0 && out_word_q.count_right == '0))
    else $error("clear command did not zero the counts");

  // A held word in the input register is never dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_word_q)))
    else $error("input word lost during a stall");

  // With the output register empty the block always takes a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty output register");

  // A filtered edge leaves the counters untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_word_q.action == qdec_pkg::ActEdge && blocked) |=>
      (pos_q[0] == $past(pos_q[0]) && pos_q[1] == $past(pos_q[1])))
    else $error("filtered edge changed a counter");

endmodule
